// ===== design/kart_pkg.sv =====
// kart_pkg: shared types and constants of the key auto-repeat tracker
// holds the opcode and state enums, register indexes and the config bundle
// no dependencies
package kart_pkg;

  localparam int KEY_W  = 8;
  localparam int TIME_W = 32;
  localparam int MS_W   = 16;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // reset values of the configuration registers
  localparam logic            ATTACHED_RST  = 1'b1;
  localparam logic [MS_W-1:0] FIRST_DLY_RST = 16'd500;
  localparam logic [MS_W-1:0] INTERVAL_RST  = 16'd100;
  localparam logic [MS_W-1:0] LATE_TOL_RST  = 16'd50;

  // register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_ATTACHED  = 2'd0,
    REG_FIRST_DLY = 2'd1,
    REG_INTERVAL  = 2'd2,
    REG_LATE_TOL  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SCAN    = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FIND,
    ST_SHIFT,
    ST_SCAN_TIME,
    ST_SCAN_EVAL,
    ST_SCAN_END
  } state_t;

  // configuration bundle from the register block to the sequencer
  typedef struct packed {
    logic            attached;
    logic [MS_W-1:0] first_delay_ms;
    logic [MS_W-1:0] repeat_interval_ms;
    logic [MS_W-1:0] late_tolerance_ms;
  } cfg_t;

endpackage

// ===== design/kart_ram.sv =====
// kart_ram: single-port-write, single-port-read synchronous memory
// read data is registered and holds until the next read; no reset on contents
// no dependencies
module kart_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/kart_cfg.sv =====
// kart_cfg: APB-style configuration registers of the tracker
// depends on kart_pkg for the register indexes and the cfg_t bundle
module kart_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kart_pkg::ADDR_W-1:0]   paddr,
  input  logic [kart_pkg::DATA_W-1:0]   pwdata,
  output logic [kart_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output kart_pkg::cfg_t                cfg
);
  import kart_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attached           <= ATTACHED_RST;
      cfg_r.first_delay_ms     <= FIRST_DLY_RST;
      cfg_r.repeat_interval_ms <= INTERVAL_RST;
      cfg_r.late_tolerance_ms  <= LATE_TOL_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ATTACHED:  cfg_r.attached           <= pwdata[0];
        REG_FIRST_DLY: cfg_r.first_delay_ms     <= pwdata[MS_W-1:0];
        REG_INTERVAL:  cfg_r.repeat_interval_ms <= pwdata[MS_W-1:0];
        REG_LATE_TOL:  cfg_r.late_tolerance_ms  <= pwdata[MS_W-1:0];
        default:       ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_ATTACHED:  prdata = {{(DATA_W-1){1'b0}}, cfg_r.attached};
      REG_FIRST_DLY: prdata = {{(DATA_W-MS_W){1'b0}}, cfg_r.first_delay_ms};
      REG_INTERVAL:  prdata = {{(DATA_W-MS_W){1'b0}}, cfg_r.repeat_interval_ms};
      REG_LATE_TOL:  prdata = {{(DATA_W-MS_W){1'b0}}, cfg_r.late_tolerance_ms};
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== design/kart_ctrl.sv =====
// kart_ctrl: sequencer that walks the held-key list and the repeat-time table
// drives both memories, holds the held count, the pending result and the out register
// depends on kart_pkg
module kart_ctrl #(
  parameter int MAX_HELD = 8,
  parameter int KEY_SPACE = 256,
  localparam int HA_W  = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1,
  localparam int CNT_W = $clog2(MAX_HELD + 1),
  localparam int TA_W  = $clog2(KEY_SPACE)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kart_pkg::cfg_t                cfg,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [kart_pkg::KEY_W-1:0]    in_key_code,
  input  logic [kart_pkg::TIME_W-1:0]   in_now_ms,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kart_pkg::KEY_W-1:0]    out_repeat_key,
  output logic                          out_last,
  // held-key memory
  output logic                          held_we,
  output logic [HA_W-1:0]               held_waddr,
  output logic [kart_pkg::KEY_W-1:0]    held_wdata,
  output logic                          held_re,
  output logic [HA_W-1:0]               held_raddr,
  input  logic [kart_pkg::KEY_W-1:0]    held_rdata,
  // repeat-time memory
  output logic                          time_we,
  output logic [TA_W-1:0]               time_waddr,
  output logic [kart_pkg::TIME_W-1:0]   time_wdata,
  output logic                          time_re,
  output logic [TA_W-1:0]               time_raddr,
  input  logic [kart_pkg::TIME_W-1:0]   time_rdata
);
  import kart_pkg::*;

  state_t              state_r, state_nxt;
  opcode_t             op_r;
  logic [KEY_W-1:0]    key_r;
  logic [TIME_W-1:0]   now_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [KEY_W-1:0]    cur_key_r, cur_key_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [KEY_W-1:0]    pend_key_r, pend_key_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]    out_key_r, out_key_nxt;
  logic                out_last_r, out_last_nxt;

  logic                accept;
  logic                key_ok;
  logic                can_emit;
  logic                out_load;
  logic [KEY_W-1:0]    out_load_key;
  logic                out_load_last;
  logic [CNT_W:0]      idx_p1, idx_p2, count_x;
  logic                has_next, has_next2, not_full;
  logic                match;
  logic                due, on_time;
  logic [TIME_W-1:0]   lateness, base_t, new_t;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid & ~in_stall;

  // list index arithmetic
  assign idx_p1    = {1'b0, idx_r} + 1'b1;
  assign idx_p2    = {1'b0, idx_r} + 2'd2;
  assign count_x   = {1'b0, count_r};
  assign has_next  = (idx_p1 < count_x);
  assign has_next2 = (idx_p2 < count_x);
  assign not_full  = (count_r < CNT_W'(MAX_HELD));
  assign key_ok    = ({24'd0, key_r} < 32'(KEY_SPACE));
  assign match     = (held_rdata == key_r);

  // repeat schedule update for the entry under evaluation
  assign due      = (time_rdata <= now_r);
  assign lateness = now_r - time_rdata;
  assign on_time  = (lateness < {{(TIME_W-MS_W){1'b0}}, cfg.late_tolerance_ms});
  assign base_t   = on_time ? time_rdata : now_r;
  assign new_t    = base_t + {{(TIME_W-MS_W){1'b0}}, cfg.repeat_interval_ms};

  assign can_emit = ~out_valid_r | ~out_stall;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= opcode_t'(in_opcode);
      key_r <= in_key_code;
      now_r <= in_now_ms;
    end
    idx_r      <= idx_nxt;
    cur_key_r  <= cur_key_nxt;
    pend_key_r <= pend_key_nxt;
    out_key_r  <= out_key_nxt;
    out_last_r <= out_last_nxt;
  end

  // next state, memory control and result handling
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cur_key_nxt    = cur_key_r;
    pend_valid_nxt = pend_valid_r;
    pend_key_nxt   = pend_key_r;
    out_load       = 1'b0;
    out_load_key   = pend_key_r;
    out_load_last  = 1'b0;
    held_we        = 1'b0;
    held_waddr     = count_r[HA_W-1:0];
    held_wdata     = key_r;
    held_re        = 1'b0;
    held_raddr     = '0;
    time_we        = 1'b0;
    time_waddr     = TA_W'(key_r);
    time_wdata     = now_r + {{(TIME_W-MS_W){1'b0}}, cfg.first_delay_ms};
    time_re        = 1'b0;
    time_raddr     = TA_W'(held_rdata);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_START;
        end
      end

      // dispatch on the opcode of the latched beat
      ST_START: begin
        state_nxt = ST_IDLE;
        idx_nxt   = '0;
        if (cfg.attached) begin
          case (op_r)
            OP_PRESS: begin
              if (key_ok) begin
                time_we = 1'b1;
                if (count_r == '0) begin
                  held_we   = 1'b1;
                  count_nxt = count_r + 1'b1;
                end else begin
                  held_re   = 1'b1;
                  state_nxt = ST_FIND;
                end
              end
            end
            OP_RELEASE: begin
              if (key_ok && count_r != '0) begin
                held_re   = 1'b1;
                state_nxt = ST_FIND;
              end
            end
            OP_SCAN: begin
              if (count_r != '0) begin
                held_re        = 1'b1;
                pend_valid_nxt = 1'b0;
                state_nxt      = ST_SCAN_TIME;
              end
            end
            default: ;
          endcase
        end
      end

      // search the list, one entry per cycle
      ST_FIND: begin
        held_raddr = idx_p1[HA_W-1:0];
        if (match) begin
          state_nxt = ST_IDLE;
          if (op_r == OP_RELEASE) begin
            if (has_next) begin
              held_re   = 1'b1;
              state_nxt = ST_SHIFT;
            end else begin
              count_nxt = count_r - 1'b1;
            end
          end
        end else if (has_next) begin
          held_re = 1'b1;
          idx_nxt = idx_p1[CNT_W-1:0];
        end else begin
          state_nxt = ST_IDLE;
          if (op_r == OP_PRESS && not_full) begin
            held_we   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
      end

      // close the gap left by a released key
      ST_SHIFT: begin
        held_we    = 1'b1;
        held_waddr = idx_r[HA_W-1:0];
        held_wdata = held_rdata;
        held_raddr = idx_p2[HA_W-1:0];
        if (has_next2) begin
          held_re = 1'b1;
          idx_nxt = idx_p1[CNT_W-1:0];
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      // key of this entry is on the list port: fetch its repeat time
      ST_SCAN_TIME: begin
        time_re     = 1'b1;
        cur_key_nxt = held_rdata;
        held_raddr  = idx_p1[HA_W-1:0];
        held_re     = has_next;
        state_nxt   = ST_SCAN_EVAL;
      end

      // compare against now, reschedule and queue the result
      ST_SCAN_EVAL: begin
        time_waddr = TA_W'(cur_key_r);
        time_wdata = new_t;
        if (!(due && pend_valid_r && !can_emit)) begin
          if (due) begin
            time_we        = 1'b1;
            out_load       = pend_valid_r;
            pend_valid_nxt = 1'b1;
            pend_key_nxt   = cur_key_r;
          end
          if (has_next) begin
            idx_nxt   = idx_p1[CNT_W-1:0];
            state_nxt = ST_SCAN_TIME;
          end else begin
            state_nxt = ST_SCAN_END;
          end
        end
      end

      // flush the final result with the last flag
      ST_SCAN_END: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (can_emit) begin
          out_load       = 1'b1;
          out_load_last  = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // output register
    out_valid_nxt = out_valid_r & out_stall;
    out_key_nxt   = out_key_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_key_nxt   = out_load_key;
      out_last_nxt  = out_load_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_repeat_key = out_key_r;
  assign out_last       = out_last_r;

endmodule

// ===== design/key_auto_repeat_tracker.sv =====
// key_auto_repeat_tracker: top level of the keyboard auto-repeat tracker
// ties the config registers, the sequencer and the two memories together
// depends on kart_pkg, kart_cfg, kart_ctrl, kart_ram
// Usage:
//   Input channel (in_valid/in_stall) takes one beat per key press (opcode 0),
//   key release (1) or repeat scan (2), each with a key code and the current
//   time in ms. A scan returns, over the out_valid/out_stall channel, one beat
//   per held key whose repeat time has come, in press order, out_last marking
//   the final one; a scan with nothing due returns no beat.
//   Registers (attached, first delay, repeat interval, late tolerance) sit on
//   the APB-style port at byte addresses 0, 4, 8 and 12; write them only idle.
//   Sequencing: a beat is taken only while the sequencer is idle; a press or
//   release walks the held-key list entry by entry, and since the held-key and
//   repeat-time memories have registered reads, a scan reads a list entry,
//   then that key's time, for each entry. A scan result is held back until the
//   next due entry is found, the last one until the end of the walk.
//   A stalled receiver holds the result register; the scan pauses when a
//   second result is ready and the register is still full.
//   Reset (rst_n low, synchronous) empties the held-key list and restores the
//   register defaults; no memory clearing pass is needed.
module key_auto_repeat_tracker #(
  parameter int MAX_HELD = 8,
  parameter int KEY_SPACE = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [kart_pkg::KEY_W-1:0]    in_key_code,
  input  logic [kart_pkg::TIME_W-1:0]   in_now_ms,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kart_pkg::KEY_W-1:0]    out_repeat_key,
  output logic                          out_last,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kart_pkg::ADDR_W-1:0]   paddr,
  input  logic [kart_pkg::DATA_W-1:0]   pwdata,
  output logic [kart_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import kart_pkg::*;

  localparam int HA_W = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int TA_W = $clog2(KEY_SPACE);

  cfg_t              cfg;
  logic              held_we, held_re;
  logic [HA_W-1:0]   held_waddr, held_raddr;
  logic [KEY_W-1:0]  held_wdata, held_rdata;
  logic              time_we, time_re;
  logic [TA_W-1:0]   time_waddr, time_raddr;
  logic [TIME_W-1:0] time_wdata, time_rdata;

  // configuration registers
  kart_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ordered held-key list
  kart_ram #(
    .DEPTH (MAX_HELD),
    .WIDTH (KEY_W)
  ) u_held_mem (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_waddr),
    .wdata (held_wdata),
    .re    (held_re),
    .raddr (held_raddr),
    .rdata (held_rdata)
  );

  // per-key next repeat time
  kart_ram #(
    .DEPTH (KEY_SPACE),
    .WIDTH (TIME_W)
  ) u_time_mem (
    .clk   (clk),
    .we    (time_we),
    .waddr (time_waddr),
    .wdata (time_wdata),
    .re    (time_re),
    .raddr (time_raddr),
    .rdata (time_rdata)
  );

  // sequencer
  kart_ctrl #(
    .MAX_HELD  (MAX_HELD),
    .KEY_SPACE (KEY_SPACE)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_key_code    (in_key_code),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_repeat_key (out_repeat_key),
    .out_last       (out_last),
    .held_we        (held_we),
    .held_waddr     (held_waddr),
    .held_wdata     (held_wdata),
    .held_re        (held_re),
    .held_raddr     (held_raddr),
    .held_rdata     (held_rdata),
    .time_we        (time_we),
    .time_waddr     (time_waddr),
    .time_wdata     (time_wdata),
    .time_re        (time_re),
    .time_raddr     (time_raddr),
    .time_rdata     (time_rdata)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for key_auto_repeat_tracker
// drives key press, release and scan beats, predicts the auto-repeat beats
// depends on kart_pkg and the key_auto_repeat_tracker rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kart_pkg::*;

  localparam int          LIST_DEPTH   = 8;
  localparam int          KEY_COUNT    = 256;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          STUCK_LIMIT  = 4000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  // one directed stimulus row, with an optional hand-typed result
  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              typed;
    logic              has_rep;
    logic [KEY_W-1:0]  rep_key;
  } stim_row_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
  } repeat_beat_t;

  // directed table: default registers (delay 500, interval 100, tolerance 50)
  localparam stim_row_t DIRECTED_ROWS [0:25] = '{
    '{OP_SCAN,    8'd0,   32'd0,          1'b1, 1'b0, 8'd0},  // empty list
    '{OP_PRESS,   8'd0,   32'd0,          1'b0, 1'b0, 8'd0},
    '{OP_SCAN,    8'd0,   32'd499,        1'b1, 1'b0, 8'd0},  // one ms early
    '{OP_SCAN,    8'd0,   32'd500,        1'b1, 1'b1, 8'd0},  // exactly due
    '{OP_SCAN,    8'd0,   32'd649,        1'b1, 1'b1, 8'd0},  // late but advancing
    '{OP_SCAN,    8'd0,   32'd750,        1'b1, 1'b1, 8'd0},  // late by tolerance
    '{OP_SCAN,    8'd0,   32'd800,        1'b1, 1'b0, 8'd0},  // schedule restarted
    '{OP_PRESS,   8'd255, 32'd800,        1'b0, 1'b0, 8'd0},
    '{OP_RELEASE, 8'd7,   32'd900,        1'b0, 1'b0, 8'd0},  // key not held
    '{OP_UNUSED,  8'd0,   32'hFFFF_FFFF,  1'b1, 1'b0, 8'd0},  // unused opcode
    '{OP_SCAN,    8'd0,   32'hFFFF_FFFF,  1'b0, 1'b0, 8'd0},
    '{OP_SCAN,    8'd0,   32'd0,          1'b1, 1'b0, 8'd0},  // no wrapped compare
    '{OP_RELEASE, 8'd0,   32'd10,         1'b0, 1'b0, 8'd0},
    '{OP_PRESS,   8'd1,   32'd100,        1'b0, 1'b0, 8'd0},
    '{OP_PRESS,   8'd2,   32'd100,        1'b0, 1'b0, 8'd0},
    '{OP_PRESS,   8'd3,   32'd100,        1'b0, 1'b0, 8'd0},
    '{OP_PRESS,   8'd4,   32'd100,        1'b0, 1'b0, 8'd0},
    '{OP_PRESS,   8'd5,   32'd100,        1'b0, 1'b0, 8'd0},
    '{OP_PRESS,   8'd6,   32'd100,        1'b0, 1'b0, 8'd0},
    '{OP_PRESS,   8'd7,   32'd100,        1'b0, 1'b0, 8'd0},
    '{OP_PRESS,   8'd8,   32'd100,        1'b0, 1'b0, 8'd0},  // list full
    '{OP_PRESS,   8'd255, 32'd200,        1'b0, 1'b0, 8'd0},  // repeated press
    '{OP_RELEASE, 8'd3,   32'd200,        1'b0, 1'b0, 8'd0},  // middle of list
    '{OP_SCAN,    8'd0,   32'd650,        1'b0, 1'b0, 8'd0},
    '{OP_PRESS,   8'd8,   32'd700,        1'b0, 1'b0, 8'd0},
    '{OP_SCAN,    8'hAA,  32'hFFFF_FFFF,  1'b0, 1'b0, 8'd0}   // eight results
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_opcode;
  logic [KEY_W-1:0]    in_key_code;
  logic [TIME_W-1:0]   in_now_ms;
  logic                out_valid;
  logic                out_stall;
  logic [KEY_W-1:0]    out_repeat_key;
  logic                out_last;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // sideband riding along with each input beat
  logic                row_typed;
  logic                row_has_rep;
  logic [KEY_W-1:0]    row_rep_key;

  // tracker model state and register copies
  bit                  attached_m;
  logic [MS_W-1:0]     first_delay_m;
  logic [MS_W-1:0]     interval_m;
  logic [MS_W-1:0]     late_tol_m;
  logic [KEY_W-1:0]    held_list [LIST_DEPTH];
  int                  held_n;
  logic [TIME_W-1:0]   repeat_at [KEY_COUNT];

  repeat_beat_t        due_repeats_q [$];
  int                  fail_count;
  int                  stuck_cycles;
  logic [TIME_W-1:0]   clock_ms;
  bit                  quiet_tail;
  bit                  hold_req;

  key_auto_repeat_tracker dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_key_code    (in_key_code),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_repeat_key (out_repeat_key),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // position of a key in the held list, -1 when absent
  function automatic int held_slot(logic [KEY_W-1:0] key);
    for (int i = 0; i < held_n; i++)
      if (held_list[i] == key) return i;
    return -1;
  endfunction

  // apply one input beat to the model, optionally queueing its repeat beats
  function automatic void predict_repeats(logic [1:0] op, logic [KEY_W-1:0] key,
                                          logic [TIME_W-1:0] now, bit record);
    int               pos;
    int               n;
    logic [KEY_W-1:0] k;
    logic [TIME_W-1:0] t;
    n = 0;
    if (!attached_m) return;
    case (op)
      OP_PRESS: begin
        repeat_at[key] = now + TIME_W'(first_delay_m);
        if (held_n < LIST_DEPTH && held_slot(key) < 0) begin
          held_list[held_n] = key;
          held_n++;
        end
      end
      OP_RELEASE: begin
        pos = held_slot(key);
        if (pos >= 0) begin
          for (int i = pos; i + 1 < held_n; i++) held_list[i] = held_list[i + 1];
          held_n--;
        end
      end
      OP_SCAN: begin
        for (int i = 0; i < held_n; i++) begin
          k = held_list[i];
          t = repeat_at[k];
          if (t <= now) begin
            if (now - t < TIME_W'(late_tol_m)) repeat_at[k] = t + TIME_W'(interval_m);
            else repeat_at[k] = now + TIME_W'(interval_m);
            if (record)
              due_repeats_q.insert(due_repeats_q.size(), repeat_beat_t'{k, 1'b0});
            n++;
          end
        end
        if (record && n > 0) due_repeats_q[due_repeats_q.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // monitor: check result beats, feed accepted input beats to the model
  always @(posedge clk) begin
    repeat_beat_t want;
    bit           moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (due_repeats_q.size() == 0) begin
          $error("repeat_key: expected no beat, actual %0d (last %0d)",
                 out_repeat_key, out_last);
          fail_count++;
        end else begin
          want = due_repeats_q.pop_front();
          if (out_repeat_key !== want.key) begin
            $error("repeat_key: expected %0d, actual %0d", want.key, out_repeat_key);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        if (row_typed) begin
          predict_repeats(in_opcode, in_key_code, in_now_ms, 1'b0);
          if (row_has_rep)
            due_repeats_q.insert(due_repeats_q.size(), repeat_beat_t'{row_rep_key, 1'b1});
        end else begin
          predict_repeats(in_opcode, in_key_code, in_now_ms, 1'b1);
        end
      end
      if (moved) stuck_cycles = 0;
      else stuck_cycles++;
    end
  end

  // watchdog on cycles with no beat moving
  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // register read, compared with the model copy
  task automatic reg_check(reg_idx_t idx);
    logic [DATA_W-1:0] want;
    case (idx)
      REG_ATTACHED:  want = DATA_W'(attached_m);
      REG_FIRST_DLY: want = DATA_W'(first_delay_m);
      REG_INTERVAL:  want = DATA_W'(interval_m);
      default:       want = DATA_W'(late_tol_m);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("%s: expected %0d, actual %0d", idx.name(), want, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // register write while idle, then read back
  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ATTACHED:  attached_m    = val[0];
      REG_FIRST_DLY: first_delay_m = val[MS_W-1:0];
      REG_INTERVAL:  interval_m    = val[MS_W-1:0];
      default:       late_tol_m    = val[MS_W-1:0];
    endcase
    @(posedge clk);
    reg_check(idx);
  endtask

  // offer one beat and hold it until taken
  task automatic send_beat(logic [1:0] op, logic [KEY_W-1:0] key, logic [TIME_W-1:0] now,
                           logic typed, logic has_rep, logic [KEY_W-1:0] rep_key);
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_key_code <= key;
    in_now_ms   <= now;
    row_typed   <= typed;
    row_has_rep <= has_rep;
    row_rep_key <= rep_key;
    do @(posedge clk); while (in_stall);
  endtask

  // random idle burst on the input side
  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // wait for every expected beat, then let the sequencer finish up
  task automatic drain();
    do @(posedge clk); while (due_repeats_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly plausible key traffic on a running clock, some noise
  task automatic send_random_item(output bit counted);
    int                r;
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    r = $urandom_range(0, 99);
    key = KEY_W'($urandom);
    if (r < 10) begin
      op  = 2'($urandom_range(0, 3));
      now = $urandom;
    end else if (r < 40) begin
      op = OP_PRESS;
      clock_ms += $urandom_range(0, 40);
      if (held_n > 0 && $urandom_range(0, 4) == 0)
        key = held_list[$urandom_range(0, held_n - 1)];
      now = clock_ms;
    end else if (r < 65) begin
      op = OP_RELEASE;
      clock_ms += $urandom_range(0, 40);
      if (held_n > 0 && $urandom_range(0, 5) != 0)
        key = held_list[$urandom_range(0, held_n - 1)];
      now = clock_ms;
    end else begin
      op = OP_SCAN;
      clock_ms += $urandom_range(0, 300);
      now = clock_ms;
    end
    counted = (op != OP_UNUSED) && attached_m;
    send_beat(op, key, now, 1'b0, 1'b0, '0);
    sender_gap();
  endtask

  task automatic run_phase(int n);
    int done;
    bit counted;
    done = 0;
    while (done < n) begin
      send_random_item(counted);
      if (counted) done++;
    end
    in_valid <= 1'b0;
    drain();
  endtask

  initial begin
    int               snap_n;
    logic [KEY_W-1:0] snap [LIST_DEPTH];
    bit               counted;
    attached_m    = ATTACHED_RST;
    first_delay_m = FIRST_DLY_RST;
    interval_m    = INTERVAL_RST;
    late_tol_m    = LATE_TOL_RST;
    held_n        = 0;
    fail_count    = 0;
    stuck_cycles  = 0;
    quiet_tail    = 1'b0;
    hold_req      = 1'b0;
    clock_ms      = 32'd1000;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= OP_PRESS;
    in_key_code <= '0;
    in_now_ms   <= '0;
    row_typed   <= 1'b0;
    row_has_rep <= 1'b0;
    row_rep_key <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults after reset
    for (int i = 0; i < 4; i++) reg_check(reg_idx_t'(i));

    // directed table
    foreach (DIRECTED_ROWS[i]) begin
      send_beat(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].now,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].has_rep, DIRECTED_ROWS[i].rep_key);
      sender_gap();
    end
    in_valid <= 1'b0;
    drain();

    // shortest timing: no first delay, interval 1, no late tolerance
    reg_write(REG_FIRST_DLY, 32'd0);
    reg_write(REG_INTERVAL, 32'd1);
    reg_write(REG_LATE_TOL, 32'd0);
    run_phase(60);

    // longest timing, starting just under the wrap point
    reg_write(REG_FIRST_DLY, 32'd65535);
    reg_write(REG_INTERVAL, 32'd65535);
    reg_write(REG_LATE_TOL, 32'd65535);
    clock_ms = 32'hFFFF_F000;
    run_phase(50);

    // detached: everything ignored
    reg_write(REG_ATTACHED, 32'd0);
    repeat (24) send_random_item(counted);
    in_valid <= 1'b0;
    drain();
    reg_write(REG_ATTACHED, 32'd1);

    // random mid-range timing
    reg_write(REG_FIRST_DLY, $urandom_range(0, 400));
    reg_write(REG_INTERVAL, $urandom_range(1, 200));
    reg_write(REG_LATE_TOL, $urandom_range(0, 100));
    run_phase(80);

    // back pressure: fill the list, hold the receiver, keep scanning
    reg_write(REG_FIRST_DLY, 32'd0);
    reg_write(REG_INTERVAL, 32'd2);
    reg_write(REG_LATE_TOL, 32'd3);
    snap_n = held_n;
    for (int i = 0; i < LIST_DEPTH; i++) snap[i] = held_list[i];
    for (int i = 0; i < snap_n; i++) begin
      clock_ms += 1;
      send_beat(OP_RELEASE, snap[i], clock_ms, 1'b0, 1'b0, '0);
    end
    for (int i = 0; i < LIST_DEPTH; i++) begin
      clock_ms += 1;
      send_beat(OP_PRESS, KEY_W'($urandom), clock_ms, 1'b0, 1'b0, '0);
    end
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      clock_ms += $urandom_range(1, 6);
      send_beat(OP_SCAN, KEY_W'($urandom), clock_ms, 1'b0, 1'b0, '0);
    end
    in_valid <= 1'b0;
    drain();

    // random small timing
    reg_write(REG_FIRST_DLY, $urandom_range(0, 200));
    reg_write(REG_INTERVAL, $urandom_range(1, 100));
    reg_write(REG_LATE_TOL, $urandom_range(0, 60));
    run_phase(100);

    // tail without idling on either side
    quiet_tail = 1'b1;
    reg_write(REG_FIRST_DLY, $urandom_range(0, 300));
    reg_write(REG_INTERVAL, $urandom_range(1, 150));
    reg_write(REG_LATE_TOL, $urandom_range(0, 80));
    run_phase(80);

    if (fail_count == 0 && due_repeats_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
